@@ sv/assert_macros.svh @@
// assertion helpers used by the matcher rtl
// both macros expect i_clk and i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SPM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/spm_pkg.sv @@
// ----------------------------------------------------------------------------
// spm_pkg
// types and constants of the streaming pattern matcher with line and column
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int PAT_BYTES       = 16;  // bytes held by the two pattern words

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

    localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;
    localparam logic [31:0] OFFSET_MAX   = 32'hFFFF_FFFF;
    localparam logic [23:0] LINE_MAX     = 24'hFF_FFFF;
    localparam logic [15:0] COLUMN_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic [31:0] match_offset;
        logic [23:0] line_number;
        logic [15:0] column_number;
    } t_out_item;

endpackage

@@ sv/stream_pattern_match_line_col.sv @@
// ----------------------------------------------------------------------------
// stream_pattern_match_line_col
// exact pattern search over a byte stream, reporting offset, line and column
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        input      i_in_valid / o_in_stall  t_in_item  (byte, end of file)
//  out       output     o_out_valid / i_out_stall t_out_item (offset, line, col)
//  cfg       input      i_cfg_valid / o_cfg_ready index + 64-bit data
//
//  one byte accepted per cycle while o_in_stall is low; an accepted byte is held
//  in the input reg, and its result, if it completes a match, goes to the result reg
//  the window compare and counter update sit between the input and result regs
//  reset (synchronous, active low) restores the pattern registers and counters
//  an output stall holds the result and, one byte later, stalls the input side
// ----------------------------------------------------------------------------
module stream_pattern_match_line_col #(
    parameter int MAX_PATTERN = spm_pkg::MAX_PATTERN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  spm_pkg::t_in_item                i_in_data,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output spm_pkg::t_out_item               o_out_data,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [spm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

`include "assert_macros.svh"

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int WIN_D  = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

    // configuration
    logic [4:0]  r_pat_len;
    logic [63:0] r_pat_low;
    logic [63:0] r_pat_high;

    // input register
    logic               r_in_valid;
    spm_pkg::t_in_item  r_in;

    // file state
    logic [7:0]  r_window [WIN_D];
    logic [31:0] r_bytes_seen;
    logic [23:0] r_line;
    logic [15:0] r_col;
    logic [31:0] n_bytes_seen;
    logic [23:0] n_line;
    logic [15:0] n_col;

    // result register
    logic                r_out_valid;
    spm_pkg::t_out_item  r_out;
    spm_pkg::t_out_item  n_out;

    logic              advance;
    logic              in_xfer;
    logic              hit;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  back;
    logic [127:0]      pat_all;
    logic [7:0]        pat  [MAX_PATTERN];
    logic [7:0]        cand [MAX_PATTERN];

    logic              eof_step;
    logic              nl_step;
    logic              file_clear;
    logic              res_nonzero;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign pat_all = {r_pat_high, r_pat_low};

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (k < spm_pkg::PAT_BYTES) begin
                pat[k] = pat_all[8*(k % spm_pkg::PAT_BYTES) +: 8];
            end else begin
                pat[k] = 8'h00;
            end
        end
        // candidate byte at distance d back from the newest
        cand[0] = r_in.data_byte;
        for (int d = 1; d < MAX_PATTERN; d++) begin
            cand[d] = r_window[d-1];
        end
    end

    always_comb begin
        if (32'(r_pat_len) > MAX_PATTERN) begin
            len = LEN_W'(MAX_PATTERN);
        end else begin
            len = LEN_W'(r_pat_len);
        end
        back = len - LEN_W'(1);

        hit = (len != '0) && (r_bytes_seen >= 32'(back));
        for (int d = 0; d < MAX_PATTERN; d++) begin
            if (LEN_W'(d) < len) begin
                if (cand[d] != pat[PIDX_W'(int'(back) - d)]) begin
                    hit = 1'b0;
                end
            end
        end

        n_out.match_offset = r_bytes_seen - 32'(back);
        n_out.line_number  = r_line;
        if (r_col > 16'(back)) begin
            n_out.column_number = r_col - 16'(back);
        end else begin
            n_out.column_number = 16'd1;  // match began on an earlier line
        end
    end

    always_comb begin
        n_bytes_seen = r_bytes_seen;
        n_line       = r_line;
        n_col        = r_col;
        if (r_in.end_of_file) begin
            n_bytes_seen = '0;
            n_line       = 24'd1;
            n_col        = 16'd1;
        end else begin
            if (r_bytes_seen != spm_pkg::OFFSET_MAX) begin
                n_bytes_seen = r_bytes_seen + 32'd1;
            end
            if (r_in.data_byte == spm_pkg::NEWLINE_BYTE) begin
                if (r_line != spm_pkg::LINE_MAX) begin
                    n_line = r_line + 24'd1;
                end
                n_col = 16'd1;
            end else if (r_col != spm_pkg::COLUMN_MAX) begin
                n_col = r_col + 16'd1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len    <= 5'd1;
            r_pat_low    <= '0;
            r_pat_high   <= '0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_bytes_seen <= '0;
            r_line       <= 24'd1;
            r_col        <= 16'd1;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    spm_pkg::CFG_PATTERN_LENGTH: r_pat_len  <= i_cfg_data[4:0];
                    spm_pkg::CFG_PATTERN_LOW:    r_pat_low  <= i_cfg_data;
                    spm_pkg::CFG_PATTERN_HIGH:   r_pat_high <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid  <= hit;
                r_bytes_seen <= n_bytes_seen;
                r_line       <= n_line;
                r_col        <= n_col;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
            if (!r_in.end_of_file) begin
                r_window[0] <= r_in.data_byte;
                for (int i = 1; i < WIN_D; i++) begin
                    r_window[i] <= r_window[i-1];
                end
            end
        end
    end

    assign eof_step    = advance && r_in.end_of_file;
    assign nl_step     = advance && !r_in.end_of_file &&
                         (r_in.data_byte == spm_pkg::NEWLINE_BYTE);
    assign file_clear  = (r_bytes_seen == 32'd0) && (r_line == 24'd1) && (r_col == 16'd1);
    assign res_nonzero = (r_out.column_number != 16'd0) && (r_out.line_number != 24'd0);

    `SPM_ASSERT_NEXT(a_eof_clears, eof_step, file_clear, "file state not cleared")
    `SPM_ASSERT_NEXT(a_newline_col, nl_step, r_col == 16'd1, "column not restarted")
    `SPM_ASSERT_IMPLY(a_result_range, r_out_valid, res_nonzero, "result line or column is zero")

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming pattern matcher with line and column
// ----------------------------------------------------------------------------
// bytes are pushed through the input channel with random gaps while the
// result channel is stalled at random. a tracker class follows the window,
// offset, line and column of the file and queues any match that each accepted
// byte completes. every result is compared against the oldest queued
// match. the pattern registers change between phases, only while idle.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAXP = spm_pkg::MAX_PATTERN_DEF;
    localparam logic [spm_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;  // not a register
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 175;
    localparam int LONG_LINE   = 40;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 1000000;

    class match_tracker;
        logic [4:0]  pat_len;
        logic [63:0] pat_lo;
        logic [63:0] pat_hi;
        logic [7:0]  window [MAXP];
        logic [31:0] offset;
        logic [23:0] line;
        logic [15:0] column;
        spm_pkg::t_out_item due_matches [$];
        int          n_errors;
        int          n_checked;
        int          n_bytes;
        int          n_files;

        function new();
            pat_len   = 5'd1;
            pat_lo    = '0;
            pat_hi    = '0;
            n_errors  = 0;
            n_checked = 0;
            n_bytes   = 0;
            n_files   = 0;
            clear_file();
        endfunction

        function void clear_file();
            foreach (window[i]) window[i] = 8'h00;
            offset = '0;
            line   = 24'd1;
            column = 16'd1;
        endfunction

        function void write_reg(logic [spm_pkg::CFG_INDEX_W-1:0] idx,
                                logic [spm_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                spm_pkg::CFG_PATTERN_LENGTH: pat_len = data[4:0];
                spm_pkg::CFG_PATTERN_LOW:    pat_lo  = data;
                spm_pkg::CFG_PATTERN_HIGH:   pat_hi  = data;
                default: ;
            endcase
        endfunction

        function logic [7:0] pattern_at(int k);
            if (k < 8)
                return pat_lo[8*k +: 8];
            if (k < 16)
                return pat_hi[8*(k-8) +: 8];
            return 8'h00;
        endfunction

        // works out the match, if any, that this byte completes
        function void take_byte(spm_pkg::t_in_item it);
            int                 len;
            int                 back;
            bit                 hit;
            spm_pkg::t_out_item m;

            len = (pat_len > MAXP) ? MAXP : int'(pat_len);
            n_bytes++;
            if (len > 0 && offset >= len - 1) begin
                hit = (pattern_at(len - 1) == it.data_byte);
                for (int d = 1; hit && d < len; d++) begin
                    if (window[d-1] != pattern_at(len - 1 - d))
                        hit = 1'b0;
                end
                if (hit) begin
                    back            = len - 1;
                    m.match_offset  = offset - 32'(back);
                    m.line_number   = line;
                    m.column_number = (column > back) ? 16'(column - back) : 16'd1;
                    due_matches     = {due_matches, m};
                end
            end
            if (it.end_of_file) begin
                n_files++;
                clear_file();
                return;
            end
            for (int d = MAXP - 1; d > 0; d--)
                window[d] = window[d-1];
            window[0] = it.data_byte;
            if (offset != spm_pkg::OFFSET_MAX)
                offset++;
            if (it.data_byte == spm_pkg::NEWLINE_BYTE) begin
                if (line != spm_pkg::LINE_MAX)
                    line++;
                column = 16'd1;
            end else if (column != spm_pkg::COLUMN_MAX) begin
                column++;
            end
        endfunction

        function void check_match(spm_pkg::t_out_item got);
            spm_pkg::t_out_item want;

            if (due_matches.size() == 0) begin
                $error("unexpected match: offset %0d line %0d column %0d",
                       got.match_offset, got.line_number, got.column_number);
                n_errors++;
                return;
            end
            want = due_matches.pop_front();
            n_checked++;
            if (got.match_offset !== want.match_offset) begin
                $error("match_offset: expected %0d, got %0d", want.match_offset,
                       got.match_offset);
                n_errors++;
            end
            if (got.line_number !== want.line_number) begin
                $error("line_number: expected %0d, got %0d", want.line_number,
                       got.line_number);
                n_errors++;
            end
            if (got.column_number !== want.column_number) begin
                $error("column_number: expected %0d, got %0d", want.column_number,
                       got.column_number);
                n_errors++;
            end
        endfunction

        function int pending();
            return due_matches.size();
        endfunction
    endclass

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    spm_pkg::t_in_item               in_item   = '0;
    logic                            in_stall;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    spm_pkg::t_out_item              out_item;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [spm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [spm_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    match_tracker tracker = new();
    bit           quiet_phase = 1'b0;
    int           n_settings  = 0;
    int           cycles      = 0;
    logic [7:0]   pat_bytes [16];

    stream_pattern_match_line_col uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stall before each transfer
    initial begin : result_side
        int hold;
        forever begin
            hold = quiet_phase ? 0 : $urandom_range(0, 14);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            tracker.check_match(out_item);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic eof);
        int                gap;
        spm_pkg::t_in_item it;

        it.data_byte   = b;
        it.end_of_file = eof;
        gap = quiet_phase ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        tracker.take_byte(it);
    endtask

    task automatic write_one(input logic [spm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [spm_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        tracker.write_reg(idx, data);
    endtask

    // length word carries random upper bits, only the low five count
    task automatic load_pattern(input logic [4:0] len);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] len_word;

        for (int k = 0; k < 8; k++) begin
            lo[8*k +: 8] = pat_bytes[k];
            hi[8*k +: 8] = pat_bytes[k+8];
        end
        len_word      = {$urandom, $urandom};
        len_word[4:0] = len;
        write_one(spm_pkg::CFG_PATTERN_LENGTH, len_word);
        write_one(spm_pkg::CFG_PATTERN_LOW, lo);
        write_one(spm_pkg::CFG_PATTERN_HIGH, hi);
        write_one(CFG_SPARE, {$urandom, $urandom});
        cfg_valid <= 1'b0;
        @(posedge clk);
        n_settings++;
    endtask

    // let every queued match come back, then give the pipe time to empty
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'h61;
            4, 5:       return spm_pkg::NEWLINE_BYTE;
            6, 7:       return 8'h62;
            default:    return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] noise_byte(input int eff);
        if (eff > 0 && $urandom_range(0, 1) == 0)
            return pat_bytes[$urandom_range(0, eff - 1)];
        return 8'($urandom);
    endfunction

    initial begin : stimulus
        logic [4:0] len_code;
        int         eff;
        int         sent;
        int         cut;
        int         bad_pos;
        logic [7:0] b;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset pattern is a single zero byte
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        settle();

        // zero pattern of three: nothing before the third byte of the file
        foreach (pat_bytes[k]) pat_bytes[k] = 8'h00;
        load_pattern(5'd3);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        settle();

        // match across a newline, column clamps to one
        pat_bytes[0] = 8'h78;
        pat_bytes[1] = spm_pkg::NEWLINE_BYTE;
        pat_bytes[2] = 8'h79;
        load_pattern(5'd3);
        push_byte(8'h78, 1'b0);
        push_byte(spm_pkg::NEWLINE_BYTE, 1'b0);
        push_byte(8'h79, 1'b1);
        settle();

        // full-width pattern of arbitrary bytes
        foreach (pat_bytes[k]) pat_bytes[k] = 8'($urandom);
        pat_bytes[0]  = 8'hFF;
        pat_bytes[15] = 8'h00;
        load_pattern(5'd16);
        for (int k = 0; k < 16; k++)
            push_byte(pat_bytes[k], k == 15);
        settle();

        // a long run of one byte on a single line, pattern at its end
        quiet_phase = 1'b1;
        pat_bytes[0] = 8'h61;
        pat_bytes[1] = 8'h62;
        load_pattern(5'd2);
        for (int k = 0; k < LONG_LINE; k++)
            push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(spm_pkg::NEWLINE_BYTE, 1'b0);
        push_byte(8'h62, 1'b1);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            case (p)
                0:       len_code = 5'd1;
                1:       len_code = 5'd16;
                2:       len_code = 5'd0;
                3:       len_code = 5'd31;
                4:       len_code = 5'd17;
                default: len_code = 5'($urandom_range(2, 15));
            endcase
            eff = (len_code > 16) ? 16 : int'(len_code);
            foreach (pat_bytes[k]) pat_bytes[k] = pick_char();
            load_pattern(len_code);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        // whole pattern, now and then with one byte spoiled
                        bad_pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : -1;
                        for (int k = 0; k < eff; k++) begin
                            b = (k == bad_pos) ? 8'($urandom) : pat_bytes[k];
                            push_byte(b, $urandom_range(0, 49) == 0);
                        end
                        sent += (eff > 0) ? eff : 0;
                        if (eff == 0) begin
                            push_byte(noise_byte(eff), $urandom_range(0, 49) == 0);
                            sent++;
                        end
                    end
                    5, 6: begin
                        cut = (eff > 1) ? $urandom_range(1, eff - 1) : 1;
                        for (int k = 0; k < cut; k++)
                            push_byte(eff > 0 ? pat_bytes[k] : noise_byte(eff),
                                      $urandom_range(0, 49) == 0);
                        sent += cut;
                    end
                    default: begin
                        push_byte(noise_byte(eff), $urandom_range(0, 49) == 0);
                        sent++;
                    end
                endcase
            end
            settle();
        end
        quiet_phase = 1'b0;

        $display("%0d bytes in %0d files under %0d pattern settings",
                 tracker.n_bytes, tracker.n_files, n_settings);
        $display("%0d matches compared, %0d errors", tracker.n_checked,
                 tracker.n_errors + tracker.pending());
        if (tracker.n_errors == 0 && tracker.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
